### sv/rafr_pkg.sv
// Shared types and codes for the ring allocator with fence release.
`default_nettype none
package rafr_pkg;

    localparam int CntW  = 17;
    localparam int SizeW = 16;
    localparam int PtW   = 32;
    localparam int LgW   = 5;
    localparam logic [LgW-1:0] LgMax = 5'd16;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_ENQ     = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_NEEDS_PROGRESS  = 3'd1,
        ST_OVERFLOW        = 3'd2,
        ST_QUEUE_FULL      = 3'd3,
        ST_NOTHING_PENDING = 3'd4
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch;
        logic    alloc_commit;
        logic    pop;
        logic    finish;
        logic    enq_write;
        logic    set_status;
        t_status status_code;
        logic    publish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd command;
        logic alloc_ok;
        logic q_empty;
        logic q_full;
        logic pend_empty;
        logic fence_done;
        logic adv;
    } t_dp_stat;

endpackage
`default_nettype wire

### sv/ring_allocator_with_fence_release.sv
// Top level of the ring allocator with fence release queue.
`default_nettype none
// Circular pool allocator with a fence-tagged release queue. One command is in
// work at a time; each command gives exactly one result beat. An allocate that
// fits, an enqueue with nothing pending, an allocate that overflows on an empty
// queue and the ignored command go straight from the start state to the result
// state. A command that walks the release queue retires entries until the walk
// empties the queue or stops at an entry whose fence is not yet complete; every
// entry costs one read of the queue memory and one fence compare. A result beat
// waiting on the output does not hold off the next command until that command
// is ready to deliver.
module ring_allocator_with_fence_release #(
    parameter int QUEUE_DEPTH = 16,
    parameter int FENCE_BITS  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_size,
    input  wire logic [31:0] i_sync_point,
    input  wire logic [31:0] i_completed_point,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [15:0]      o_offset,
    output logic             o_advanced
);
    import rafr_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    rafr_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .FENCE_BITS  (FENCE_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_command         (i_command),
        .i_size            (i_size),
        .i_sync_point      (i_sync_point),
        .i_completed_point (i_completed_point),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .o_status          (o_status),
        .o_offset          (o_offset),
        .o_advanced        (o_advanced)
    );

    rafr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // A command in work holds off the next one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a command was still in work");

    // Retiring never happens on an overflow or an empty enqueue.
    a_adv_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_advanced) |->
            (o_status != ST_OVERFLOW && o_status != ST_NOTHING_PENDING))
        else $error("retire reported with a status that excludes retiring");

    // Only a granted block carries an offset.
    a_offset_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_offset != '0) |-> (o_status == ST_OK))
        else $error("offset given without a successful allocate");

endmodule
`default_nettype wire

### sv/rafr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rafr_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### sv/rafr_dp.sv
// Datapath: range counters, release queue storage, allocation check and result registers.
`default_nettype none
module rafr_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int FENCE_BITS  = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [4:0]            i_cfg_data,
    input  wire logic [1:0]            i_command,
    input  wire logic [15:0]           i_size,
    input  wire logic [31:0]           i_sync_point,
    input  wire logic [31:0]           i_completed_point,
    input  wire rafr_pkg::t_dp_cmd     i_cmd,
    output rafr_pkg::t_dp_stat         o_stat,
    output logic [2:0]                 o_status,
    output logic [15:0]                o_offset,
    output logic                       o_advanced
);
    import rafr_pkg::*;

    localparam int IdxW = $clog2(QUEUE_DEPTH);
    localparam int EntW = FENCE_BITS + CntW;
    localparam logic [IdxW-1:0] IdxLast = IdxW'(QUEUE_DEPTH - 1);

    logic [LgW-1:0]        r_cfg_lg;
    logic [CntW-1:0]       r_head, r_tail, r_last_end;
    logic [IdxW-1:0]       r_rd_idx, r_wr_idx;
    t_cmd                  r_cmd;
    logic [SizeW-1:0]      r_size;
    logic [PtW-1:0]        r_sync, r_done;
    t_status               r_status, r_o_status;
    logic [SizeW-1:0]      r_offset, r_o_offset;
    logic                  r_adv, r_o_adv;

    logic [IdxW-1:0]       rd_next, wr_next;
    logic [EntW-1:0]       ram_rdata, ram_wdata;
    logic [FENCE_BITS-1:0] ent_fence, done_f, sync_f;
    logic [CntW-1:0]       ent_end;
    logic [LgW-1:0]        lg;
    logic [CntW-1:0]       pool, size_c, alloc_where, alloc_tail;
    logic                  alloc_ok;

    assign rd_next = (r_rd_idx == IdxLast) ? '0 : r_rd_idx + IdxW'(1);
    assign wr_next = (r_wr_idx == IdxLast) ? '0 : r_wr_idx + IdxW'(1);

    // Fences are compared on their low FENCE_BITS bits.
    assign done_f    = FENCE_BITS'(64'(r_done));
    assign sync_f    = FENCE_BITS'(64'(r_sync));
    assign ent_fence = ram_rdata[EntW-1:CntW];
    assign ent_end   = ram_rdata[CntW-1:0];
    assign ram_wdata = {sync_f, r_tail};

    rafr_ram #(
        .WIDTH (EntW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (i_cmd.enq_write),
        .i_waddr (r_wr_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    // Placement: at the tail, or at the front when the tail end lacks room.
    always_comb begin
        lg          = (r_cfg_lg > LgMax) ? LgMax : r_cfg_lg;
        pool        = CntW'(1) << lg;
        size_c      = {1'b0, r_size};
        alloc_ok    = 1'b0;
        alloc_where = r_tail;
        alloc_tail  = r_tail + size_c;
        if (r_tail < r_head) begin
            alloc_ok = (r_head - r_tail) > size_c;
        end else if ((r_tail <= pool) && ((pool - r_tail) >= size_c)) begin
            alloc_ok = 1'b1;
        end else if (r_head > size_c) begin
            alloc_ok    = 1'b1;
            alloc_where = '0;
            alloc_tail  = size_c;
        end
    end

    always_comb begin
        o_stat.command    = r_cmd;
        o_stat.alloc_ok   = alloc_ok;
        o_stat.q_empty    = (r_rd_idx == r_wr_idx);
        o_stat.q_full     = (wr_next == r_rd_idx);
        o_stat.pend_empty = (r_rd_idx == r_wr_idx) ? (r_head == r_tail)
                                                   : (r_last_end == r_tail);
        o_stat.fence_done = (ent_fence <= done_f);
        o_stat.adv        = r_adv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_lg <= LgMax;
            r_head   <= '0;
            r_tail   <= '0;
            r_rd_idx <= '0;
            r_wr_idx <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_lg <= i_cfg_data;
            end
            if (i_cmd.alloc_commit) begin
                r_tail <= alloc_tail;
            end
            if (i_cmd.pop) begin
                r_head   <= ent_end;
                r_rd_idx <= rd_next;
            end
            // An empty range goes back to the start of the pool.
            if (i_cmd.finish && (r_head == r_tail)) begin
                r_head <= '0;
                r_tail <= '0;
            end
            if (i_cmd.enq_write) begin
                r_wr_idx <= wr_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd    <= t_cmd'(i_command);
            r_size   <= i_size;
            r_sync   <= i_sync_point;
            r_done   <= i_completed_point;
            r_status <= ST_OK;
            r_offset <= '0;
            r_adv    <= 1'b0;
        end
        if (i_cmd.alloc_commit) begin
            r_offset <= alloc_where[SizeW-1:0];
        end
        if (i_cmd.pop) begin
            r_adv <= 1'b1;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.enq_write) begin
            r_last_end <= r_tail;
        end
        if (i_cmd.publish) begin
            r_o_status <= r_status;
            r_o_offset <= r_offset;
            r_o_adv    <= r_adv;
        end
    end

    assign o_status   = r_o_status;
    assign o_offset   = r_o_offset;
    assign o_advanced = r_o_adv;

endmodule
`default_nettype wire

### sv/rafr_ctrl.sv
// Controller: sequences one command through allocation, queue retirement and result hand-off.
`default_nettype none
module rafr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    input  wire rafr_pkg::t_dp_stat i_stat,
    output rafr_pkg::t_dp_cmd       o_cmd
);
    import rafr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_RD,
        S_CHK,
        S_FIN,
        S_POST,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_START;
                end
            end
            S_START: begin
                unique case (i_stat.command)
                    CMD_ALLOC: begin
                        if (i_stat.alloc_ok) begin
                            o_cmd.alloc_commit = 1'b1;
                            n_state            = S_DONE;
                        end else if (i_stat.q_empty) begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = ST_OVERFLOW;
                            n_state           = S_DONE;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    CMD_ENQ: begin
                        if (i_stat.pend_empty) begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = ST_NOTHING_PENDING;
                            n_state           = S_DONE;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    CMD_ADVANCE: n_state = S_RD;
                    CMD_NOP:     n_state = S_DONE;
                endcase
            end
            // The queue memory read issued here is checked in the next cycle.
            S_RD: begin
                n_state = i_stat.q_empty ? S_FIN : S_CHK;
            end
            S_CHK: begin
                if (i_stat.fence_done) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_POST;
            end
            S_POST: begin
                unique case (i_stat.command)
                    CMD_ALLOC: begin
                        if (i_stat.adv && i_stat.alloc_ok) begin
                            o_cmd.alloc_commit = 1'b1;
                        end else begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = ST_NEEDS_PROGRESS;
                        end
                    end
                    CMD_ENQ: begin
                        if (i_stat.q_full) begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = ST_QUEUE_FULL;
                        end else begin
                            o_cmd.enq_write = 1'b1;
                        end
                    end
                    CMD_ADVANCE, CMD_NOP: begin
                    end
                endcase
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

### verif/ring_allocator_with_fence_release_test.sv
// Self-checking testbench for the ring allocator with fence release queue.
module ring_allocator_with_fence_release_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rafr_pkg::*;

    localparam int QDepth  = 16;
    localparam int ShowMax = 10;
    localparam int Phases  = 10;
    localparam int PerPhase = 58;

    typedef struct packed {
        t_status     status;
        logic [15:0] offset;
        logic        advanced;
    } t_alloc_beat;

    // Tracks the pool counters and the release ring, and holds the result beats still owed.
    class alloc_scoreboard;
        logic [LgW-1:0]  pool_lg;
        logic [CntW-1:0] head;
        logic [CntW-1:0] tail;
        int              rd_idx;
        int              wr_idx;
        logic [PtW-1:0]  rel_fence [QDepth];
        logic [CntW-1:0] rel_end [QDepth];
        t_alloc_beat     owed_q [$];
        int              mismatches;
        int              beats;
        int              status_seen [5];

        function new();
            pool_lg = LgMax;
            head = '0;
            tail = '0;
            rd_idx = 0;
            wr_idx = 0;
            mismatches = 0;
            beats = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int step_idx(int i);
            return (i == QDepth - 1) ? 0 : i + 1;
        endfunction

        function int back_idx(int i);
            return (i == 0) ? QDepth - 1 : i - 1;
        endfunction

        function bit place(int unsigned sz, output logic [CntW-1:0] at);
            int unsigned pool;
            pool = 1 << ((pool_lg > LgMax) ? LgMax : pool_lg);
            at = '0;
            if (tail < head) begin
                if (head - tail > sz) begin
                    at = tail;
                    tail = CntW'(tail + sz);
                    return 1'b1;
                end
                return 1'b0;
            end
            if (tail <= pool && pool - tail >= sz) begin
                at = tail;
                tail = CntW'(tail + sz);
                return 1'b1;
            end
            // Wrapping to the front must leave one unit free so full never looks empty.
            if (head > sz) begin
                at = '0;
                tail = CntW'(sz);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit retire(logic [PtW-1:0] done);
            bit any;
            any = 1'b0;
            for (int n = 0; n < QDepth; n++) begin
                if (rd_idx == wr_idx) break;
                if (rel_fence[rd_idx] > done) break;
                head = rel_end[rd_idx];
                rd_idx = step_idx(rd_idx);
                any = 1'b1;
            end
            if (head == tail) begin
                head = '0;
                tail = '0;
            end
            return any;
        endfunction

        function void note(t_cmd cmd, logic [15:0] size, logic [31:0] sync, logic [31:0] done);
            t_alloc_beat     want;
            logic [CntW-1:0] at;
            bit              none_pending;
            want.status = ST_OK;
            want.offset = '0;
            want.advanced = 1'b0;
            case (cmd)
                CMD_ALLOC: begin
                    if (place(size, at)) begin
                        want.offset = at[15:0];
                    end else if (rd_idx == wr_idx) begin
                        want.status = ST_OVERFLOW;
                    end else begin
                        want.advanced = retire(done);
                        if (want.advanced && place(size, at)) want.offset = at[15:0];
                        else want.status = ST_NEEDS_PROGRESS;
                    end
                end
                CMD_ENQ: begin
                    if (rd_idx == wr_idx) none_pending = (head == tail);
                    else none_pending = (rel_end[back_idx(wr_idx)] == tail);
                    if (none_pending) begin
                        want.status = ST_NOTHING_PENDING;
                    end else begin
                        want.advanced = retire(done);
                        if (step_idx(wr_idx) == rd_idx) begin
                            want.status = ST_QUEUE_FULL;
                        end else begin
                            rel_fence[wr_idx] = sync;
                            rel_end[wr_idx] = tail;
                            wr_idx = step_idx(wr_idx);
                        end
                    end
                end
                CMD_ADVANCE: want.advanced = retire(done);
                default: ;
            endcase
            owed_q.push_back(want);
        endfunction

        function void complain(string what);
            mismatches++;
            if (mismatches <= ShowMax) $display("mismatch: %s", what);
        endfunction

        function void check(logic [2:0] st, logic [15:0] off, logic adv);
            t_alloc_beat want;
            if (owed_q.size() == 0) begin
                complain($sformatf({"result beat with nothing owed: ",
                                    "status=%0d offset=%0d advanced=%0d"},
                                   st, off, adv));
                return;
            end
            want = owed_q.pop_front();
            status_seen[int'(want.status)]++;
            if (st !== want.status || off !== want.offset || adv !== want.advanced)
                complain($sformatf({"beat %0d: expected status=%0d offset=%0d advanced=%0d, ",
                                    "got status=%0d offset=%0d advanced=%0d"},
                                   beats, want.status, want.offset, want.advanced, st, off, adv));
            beats++;
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic [1:0]  command = '0;
    logic [15:0] size = '0;
    logic [31:0] sync = '0;
    logic [31:0] done = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [2:0]  status;
    logic [15:0] offset;
    logic        advanced;

    alloc_scoreboard board;
    bit          quiet = 1'b0;
    int          stall_left = 0;
    int          sent = 0;
    int          settings = 1;
    logic [31:0] fence_next;
    logic [31:0] fence_floor;

    ring_allocator_with_fence_release #(
        .QUEUE_DEPTH(QDepth),
        .FENCE_BITS (PtW)
    ) DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_command        (command),
        .i_size           (size),
        .i_sync_point     (sync),
        .i_completed_point(done),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_status         (status),
        .o_offset         (offset),
        .o_advanced       (advanced)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Result side: random stall runs, checked at the rising edge.
    always @(negedge clk) begin
        int n;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            n = idle_len();
            if (n == 0) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b1;
                stall_left = n - 1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) board.check(status, offset, advanced);
    end

    task automatic send_beat(t_cmd c, logic [15:0] sz, logic [31:0] sp, logic [31:0] cp);
        int gap;
        gap = idle_len();
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        command <= c;
        size <= sz;
        sync <= sp;
        done <= cp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note(c, sz, sp, cp);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.outstanding() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic write_pool_lg(logic [4:0] v);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        board.pool_lg = v;
        @(negedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // Mostly allocate and release in fence order; starving phases hold the completed point back.
    task automatic random_beat(bit starve, output bit counted);
        int          r;
        int unsigned pool;
        int unsigned cap;
        t_cmd        c;
        logic [15:0] sz;
        logic [31:0] sp;
        logic [31:0] cp;
        pool = 1 << ((board.pool_lg > LgMax) ? LgMax : board.pool_lg);
        cap = (pool / 3 == 0) ? 1 : pool / 3;
        r = $urandom_range(0, 99);
        if (r < 8) sz = 16'($urandom);
        else if (r < 14) sz = (pool > 65535) ? 16'hFFFF : 16'(pool - $urandom_range(0, 1));
        else if (r < 20) sz = '0;
        else sz = 16'($urandom_range(1, cap));
        sp = ($urandom_range(0, 99) < 3) ? $urandom : fence_next;
        r = $urandom_range(0, 99);
        if (r < 8) cp = $urandom;
        else if (starve) cp = fence_floor;
        else cp = fence_next - $urandom_range(0, 12);
        r = $urandom_range(0, 99);
        if (r < 45) c = CMD_ALLOC;
        else if (r < 75) c = CMD_ENQ;
        else if (r < 93) c = CMD_ADVANCE;
        else c = CMD_NOP;
        if (c == CMD_ENQ) fence_next = fence_next + $urandom_range(1, 3);
        send_beat(c, sz, sp, cp);
        counted = (c != CMD_NOP);
    endtask

    initial begin
        logic [4:0] phase_lg [Phases];
        bit  phase_starve [Phases];
        int  cnt;
        bit  counted;
        int  waited;
        phase_lg = '{5'd16, 5'd4, 5'd8, 5'd2, 5'd0, 5'd31, 5'd1, 5'd12, 5'd6, 5'd16};
        phase_starve = '{0, 0, 1, 0, 0, 0, 1, 0, 1, 0};
        board = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: counter extremes, overflow, strict wrap, fence compare edges, ignored command.
        send_beat(CMD_ENQ,     16'd0,     32'd0,          32'd0);
        send_beat(CMD_ADVANCE, 16'd0,     32'd0,          32'hFFFF_FFFF);
        send_beat(CMD_ALLOC,   16'hFFFF,  32'd0,          32'd0);
        send_beat(CMD_ALLOC,   16'd1,     32'd0,          32'd0);
        send_beat(CMD_ALLOC,   16'd0,     32'd0,          32'd0);
        send_beat(CMD_ALLOC,   16'd1,     32'd0,          32'd0);
        send_beat(CMD_ENQ,     16'd0,     32'hFFFF_FFFF,  32'd0);
        send_beat(CMD_ENQ,     16'd0,     32'd1,          32'd0);
        send_beat(CMD_ALLOC,   16'd1,     32'd0,          32'd0);
        send_beat(CMD_ALLOC,   16'd1,     32'd0,          32'hFFFF_FFFE);
        send_beat(CMD_ALLOC,   16'd1,     32'd0,          32'hFFFF_FFFF);
        send_beat(CMD_NOP,     16'hFFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_beat(CMD_ALLOC,   16'd59999, 32'd0,          32'd0);
        send_beat(CMD_ENQ,     16'd0,     32'd5,          32'd0);
        send_beat(CMD_ALLOC,   16'd5000,  32'd0,          32'd0);
        send_beat(CMD_ENQ,     16'd0,     32'd6,          32'd0);
        send_beat(CMD_ADVANCE, 16'd0,     32'd0,          32'd5);
        send_beat(CMD_ALLOC,   16'd1000,  32'd0,          32'd5);
        send_beat(CMD_ALLOC,   16'd59000, 32'd0,          32'd5);
        send_beat(CMD_ALLOC,   16'd58999, 32'd0,          32'd5);
        send_beat(CMD_ENQ,     16'd0,     32'd7,          32'd6);
        send_beat(CMD_ALLOC,   16'd1,     32'd0,          32'd0);
        send_beat(CMD_ADVANCE, 16'd0,     32'd0,          32'hFFFF_FFFF);
        send_beat(CMD_ENQ,     16'd0,     32'd8,          32'd0);
        send_beat(CMD_ADVANCE, 16'd0,     32'd0,          32'd8);
        sent = 25;

        fence_next = 32'd9 + $urandom_range(0, 1000);
        for (int p = 0; p < Phases; p++) begin
            write_pool_lg(phase_lg[p]);
            quiet = (p == 3 || p == 7);
            // Jump the fences high once so the upper bits of both points get exercised.
            if (p == 5) fence_next = 32'hFFFF_0000 + $urandom_range(0, 255);
            fence_floor = fence_next - 1;
            cnt = 0;
            while (cnt < PerPhase) begin
                random_beat(phase_starve[p], counted);
                if (counted) cnt++;
            end
            sent += cnt;
        end
        quiet = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (board.outstanding() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);

        $display({"Ran %0d commands over %0d pool-size settings: ",
                  "ok %0d, needs-progress %0d, overflow %0d."},
                 sent, settings, board.status_seen[0], board.status_seen[1],
                 board.status_seen[2]);
        $display("Queue-full %0d, nothing-pending %0d, mismatches %0d, beats still owed %0d.",
                 board.status_seen[3], board.status_seen[4], board.mismatches, board.outstanding());
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
